FILE: hdl/dcrb_pkg.sv
// Package for the DMA channel register block: item/result types and constants.
// No dependencies; used by dcrb_core and dma_channel_register_block_top.
`default_nettype none

package dcrb_pkg;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_DISK  = 2'd2;

  localparam logic [3:0] PORT_STATUS = 4'd8;

  localparam logic [1:0] CH_DISK = 2'd0;
  localparam logic [1:0] CH_TERM = 2'd3;

  localparam logic [7:0]  BIT_TERM = 8'h08;
  localparam logic [7:0]  BIT_DISK = 8'h01;
  localparam logic [15:0] COUNT_RELOAD = 16'h3fff;

  typedef struct packed {
    logic [15:0] offered_bytes;
    logic        to_memory;
    logic [7:0]  write_data;
    logic [3:0]  port;
    logic [1:0]  func;
  } item_t;

  typedef struct packed {
    logic        irq_request;
    logic [14:0] xfer_length;
    logic [15:0] xfer_address;
    logic [1:0]  xfer_channel;
    logic        xfer_done;
    logic [7:0]  read_data;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/dcrb_core.sv
// Register state and single-pass update logic of the DMA channel register block.
// Depends on dcrb_pkg.
`default_nettype none

module dcrb_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire dcrb_pkg::item_t  item,
  output dcrb_pkg::result_t     result
);

  logic [15:0] channel_address [4];
  logic [15:0] channel_count [4];
  logic [7:0]  mode_register;
  logic [7:0]  status_register;
  logic        write_high_flag;
  logic        read_high_flag;

  logic [15:0] channel_address_next [4];
  logic [15:0] channel_count_next [4];
  logic [7:0]  mode_register_next;
  logic [7:0]  status_register_next;
  logic        write_high_flag_next;
  logic        read_high_flag_next;

  logic [1:0]  ch;
  logic [15:0] sel_value;
  logic [14:0] disk_len;
  logic        fin;
  logic [1:0]  fin_ch;
  logic [7:0]  fin_bit;
  logic [14:0] fin_len;

  assign ch        = item.port[2:1];
  assign sel_value = item.port[0] ? channel_count[ch] : channel_address[ch];
  assign disk_len  = {1'b0, channel_count[dcrb_pkg::CH_DISK][13:0]} + 15'd1;

  always_comb begin
    channel_address_next = channel_address;
    channel_count_next   = channel_count;
    mode_register_next   = mode_register;
    status_register_next = status_register;
    write_high_flag_next = write_high_flag;
    read_high_flag_next  = read_high_flag;
    result               = '0;
    fin                  = 1'b0;
    fin_ch               = dcrb_pkg::CH_DISK;
    fin_bit              = dcrb_pkg::BIT_DISK;

    case (item.func)
      dcrb_pkg::FUNC_READ: begin
        if (item.port == dcrb_pkg::PORT_STATUS) begin
          result.read_data     = status_register;
          status_register_next = '0;
          read_high_flag_next  = 1'b0;
        end else if (!item.port[3]) begin
          result.read_data    = read_high_flag ? sel_value[15:8] : sel_value[7:0];
          read_high_flag_next = !read_high_flag;
        end
      end
      dcrb_pkg::FUNC_WRITE: begin
        if (item.port == dcrb_pkg::PORT_STATUS) begin
          mode_register_next   = item.write_data;
          write_high_flag_next = 1'b0;
          read_high_flag_next  = 1'b0;
          if ((item.write_data & dcrb_pkg::BIT_TERM) != '0) begin
            fin     = 1'b1;
            fin_ch  = dcrb_pkg::CH_TERM;
            fin_bit = dcrb_pkg::BIT_TERM;
          end
        end else if (!item.port[3]) begin
          if (item.port[0]) begin
            if (write_high_flag) channel_count_next[ch][15:8] = item.write_data;
            else                 channel_count_next[ch][7:0]  = item.write_data;
          end else begin
            if (write_high_flag) channel_address_next[ch][15:8] = item.write_data;
            else                 channel_address_next[ch][7:0]  = item.write_data;
          end
          write_high_flag_next = !write_high_flag;
        end
      end
      dcrb_pkg::FUNC_DISK: begin
        if ((mode_register & dcrb_pkg::BIT_DISK) != '0 &&
            (!item.to_memory || item.offered_bytes >= {1'b0, disk_len})) begin
          fin = 1'b1;
        end
      end
      default: begin
      end
    endcase

    fin_len = {1'b0, channel_count[fin_ch][13:0]} + 15'd1;

    if (fin) begin
      result.xfer_done            = 1'b1;
      result.xfer_channel         = fin_ch;
      result.xfer_address         = channel_address[fin_ch];
      result.xfer_length          = fin_len;
      result.irq_request          = 1'b1;
      channel_address_next[fin_ch] = channel_address[fin_ch] + {1'b0, fin_len};
      channel_count_next[fin_ch]   = dcrb_pkg::COUNT_RELOAD;
      mode_register_next           = mode_register_next & ~fin_bit;
      status_register_next         = status_register_next | fin_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        channel_address[i] <= '0;
        channel_count[i]   <= '0;
      end
      mode_register   <= '0;
      status_register <= '0;
      write_high_flag <= 1'b0;
      read_high_flag  <= 1'b0;
    end else if (en) begin
      channel_address <= channel_address_next;
      channel_count   <= channel_count_next;
      mode_register   <= mode_register_next;
      status_register <= status_register_next;
      write_high_flag <= write_high_flag_next;
      read_high_flag  <= read_high_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dma_channel_register_block_top.sv
// DMA channel register block: input register, update core, result register.
// Path: input register, then result register; one item per cycle unless m_tready stalls the output.
// Each item is applied to the channel state in the cycle it leaves the input register.
// A held result stalls the input register; s_tready drops while both are full.
// rst (synchronous) clears all channel, mode, status and flip-flop state.
// Depends on dcrb_pkg and dcrb_core.
`default_nettype none

module dma_channel_register_block_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // port[3:0], write_data[11:4], to_memory[12],
                                     // offered_bytes[28:13], zero[31:29]
  input  wire logic [1:0]  s_tuser,  // func[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata   // read_data[7:0], xfer_done[8], xfer_channel[10:9],
                                     // xfer_address[26:11], xfer_length[41:27],
                                     // irq_request[42], zero[47:43]
);

  logic              in_valid;
  dcrb_pkg::item_t   in_item;
  logic              out_valid;
  dcrb_pkg::result_t out_result;
  dcrb_pkg::result_t core_result;
  logic              advance;
  logic              process;

  assign advance  = !out_valid || m_tready;
  assign process  = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance)  out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= {s_tdata[28:0], s_tuser};
    end
    if (process) begin
      out_result <= core_result;
    end
  end

  dcrb_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (process),
    .item   (in_item),
    .result (core_result)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_result};

endmodule

`default_nettype wire

FILE: dv/dcrb_checker.sv
// Checker for the DMA channel register block: watches both stream channels,
// keeps its own copy of the channel registers and compares every result.
// Depends on dcrb_pkg.
module dcrb_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,  // port[3:0], write_data[11:4], to_memory[12],
                                     // offered_bytes[28:13], zero[31:29]
  input  wire logic [1:0]  s_tuser,  // func[1:0]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [47:0] m_tdata,  // read_data[7:0], xfer_done[8], xfer_channel[10:9],
                                     // xfer_address[26:11], xfer_length[41:27],
                                     // irq_request[42], zero[47:43]
  output int               fail_count,
  output int               pending,
  output int               xfer_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 8;

  logic [15:0]       chan_addr [4];
  logic [15:0]       chan_count [4];
  logic [7:0]        mode_q;
  logic [7:0]        status_q;
  logic              wr_hi;
  logic              rd_hi;
  dcrb_pkg::result_t bus_replies [DEPTH];
  logic [2:0]        rd_ptr;
  logic [2:0]        wr_ptr;
  int                held;

  initial begin
    fail_count = 0;
    pending    = 0;
    xfer_count = 0;
  end

  task automatic complete_channel(input logic [1:0] ch, input logic [7:0] mask,
                                  inout dcrb_pkg::result_t r);
    logic [14:0] len;
    len = {1'b0, chan_count[ch][13:0]} + 15'd1;
    r.xfer_done    = 1'b1;
    r.xfer_channel = ch;
    r.xfer_address = chan_addr[ch];
    r.xfer_length  = len;
    r.irq_request  = 1'b1;
    chan_addr[ch]  = chan_addr[ch] + {1'b0, len};
    chan_count[ch] = dcrb_pkg::COUNT_RELOAD;
    mode_q         = mode_q & ~mask;
    status_q       = status_q | mask;
    xfer_count++;
  endtask

  task automatic apply_bus_access(input dcrb_pkg::item_t it, output dcrb_pkg::result_t r);
    logic [1:0]  ch;
    logic [15:0] v;
    logic [14:0] disk_len;
    r  = '0;
    ch = it.port[2:1];
    case (it.func)
      dcrb_pkg::FUNC_READ: begin
        if (it.port == dcrb_pkg::PORT_STATUS) begin
          r.read_data = status_q;
          status_q    = '0;
          rd_hi       = 1'b0;
        end else if (it.port < dcrb_pkg::PORT_STATUS) begin
          v = it.port[0] ? chan_count[ch] : chan_addr[ch];
          r.read_data = rd_hi ? v[15:8] : v[7:0];
          rd_hi = ~rd_hi;
        end
      end
      dcrb_pkg::FUNC_WRITE: begin
        if (it.port == dcrb_pkg::PORT_STATUS) begin
          mode_q = it.write_data;
          wr_hi  = 1'b0;
          rd_hi  = 1'b0;
          if ((mode_q & dcrb_pkg::BIT_TERM) != '0)
            complete_channel(dcrb_pkg::CH_TERM, dcrb_pkg::BIT_TERM, r);
        end else if (it.port < dcrb_pkg::PORT_STATUS) begin
          if (it.port[0]) begin
            if (wr_hi) chan_count[ch][15:8] = it.write_data;
            else chan_count[ch][7:0] = it.write_data;
          end else begin
            if (wr_hi) chan_addr[ch][15:8] = it.write_data;
            else chan_addr[ch][7:0] = it.write_data;
          end
          wr_hi = ~wr_hi;
        end
      end
      dcrb_pkg::FUNC_DISK: begin
        if ((mode_q & dcrb_pkg::BIT_DISK) != '0) begin
          disk_len = {1'b0, chan_count[0][13:0]} + 15'd1;
          if (!it.to_memory || it.offered_bytes >= {1'b0, disk_len})
            complete_channel(dcrb_pkg::CH_DISK, dcrb_pkg::BIT_DISK, r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    dcrb_pkg::result_t want;
    dcrb_pkg::result_t got;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        chan_addr[i]  = '0;
        chan_count[i] = '0;
      end
      mode_q   = '0;
      status_q = '0;
      wr_hi    = 1'b0;
      rd_hi    = 1'b0;
      rd_ptr   = '0;
      wr_ptr   = '0;
      held     = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = dcrb_pkg::result_t'(m_tdata[42:0]);
        if (held == 0) begin
          $error("unexpected result transfer: %h", m_tdata);
          fail_count++;
        end else begin
          want   = bus_replies[rd_ptr];
          rd_ptr = rd_ptr + 3'd1;
          held--;
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
            fail_count++;
          end
          if (got.xfer_done !== want.xfer_done) begin
            $error("xfer_done: expected %0h, actual %0h", want.xfer_done, got.xfer_done);
            fail_count++;
          end
          if (got.xfer_channel !== want.xfer_channel) begin
            $error("xfer_channel: expected %0h, actual %0h",
                   want.xfer_channel, got.xfer_channel);
            fail_count++;
          end
          if (got.xfer_address !== want.xfer_address) begin
            $error("xfer_address: expected %0h, actual %0h",
                   want.xfer_address, got.xfer_address);
            fail_count++;
          end
          if (got.xfer_length !== want.xfer_length) begin
            $error("xfer_length: expected %0h, actual %0h",
                   want.xfer_length, got.xfer_length);
            fail_count++;
          end
          if (got.irq_request !== want.irq_request) begin
            $error("irq_request: expected %0h, actual %0h",
                   want.irq_request, got.irq_request);
            fail_count++;
          end
          if (m_tdata[47:43] !== 5'b0) begin
            $error("padding: expected 0, actual %0h", m_tdata[47:43]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_bus_access(dcrb_pkg::item_t'({s_tdata[28:0], s_tuser}), want);
        if (held == DEPTH) begin
          $error("too many transfers in flight: expected below %0d, actual %0d",
                 DEPTH, held);
          fail_count++;
        end else begin
          bus_replies[wr_ptr] = want;
          wr_ptr = wr_ptr + 3'd1;
          held++;
        end
      end
    end
    pending = held;
  end

endmodule

FILE: dv/tb.sv
// Testbench top for dma_channel_register_block_top: drives register and disk
// request transfers with random bursts and output stalls; dcrb_checker scores.
// Depends on dcrb_pkg, dcrb_checker and the block RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;

  int fail_count;
  int pending;
  int xfer_count;
  int sent       = 0;
  int burst_left = 0;
  int ready_left = 0;
  int ready_mode = 0;

  dma_channel_register_block_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  dcrb_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .xfer_count (xfer_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // output stalls: always ready, coin flip, or solid stall
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = (ready_mode == 2) ? $urandom_range(1, 12) : $urandom_range(5, 60);
    end
    ready_left--;
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= 1'b0;
    endcase
  end

  function automatic logic [3:0] addr_port(input logic [1:0] ch);
    return {1'b0, ch, 1'b0};
  endfunction

  function automatic logic [3:0] count_port(input logic [1:0] ch);
    return {1'b0, ch, 1'b1};
  endfunction

  task automatic send(input logic [1:0] f, input logic [3:0] p, input logic [7:0] wd,
                      input logic tm, input logic [15:0] ob);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, ob, tm, wd, p};
    s_tuser  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic write_reg(input logic [3:0] p, input logic [7:0] wd);
    send(dcrb_pkg::FUNC_WRITE, p, wd, 1'($urandom), 16'($urandom));
  endtask

  task automatic read_reg(input logic [3:0] p);
    send(dcrb_pkg::FUNC_READ, p, 8'($urandom), 1'($urandom), 16'($urandom));
  endtask

  task automatic disk_request(input logic tm, input logic [15:0] ob);
    send(dcrb_pkg::FUNC_DISK, 4'($urandom), 8'($urandom), tm, ob);
  endtask

  task automatic program_channel;
    logic [1:0]  ch;
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [15:0] len;
    logic [15:0] ob;
    ch   = ($urandom_range(0, 2) == 0) ? 2'($urandom) : dcrb_pkg::CH_DISK;
    addr = 16'($urandom);
    cnt  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
    len  = {2'b00, cnt[13:0]} + 16'd1;
    write_reg(dcrb_pkg::PORT_STATUS, 8'($urandom) & ~dcrb_pkg::BIT_DISK);
    write_reg(addr_port(ch), addr[7:0]);
    write_reg(addr_port(ch), addr[15:8]);
    write_reg(count_port(ch), cnt[7:0]);
    write_reg(count_port(ch), cnt[15:8]);
    write_reg(dcrb_pkg::PORT_STATUS, 8'($urandom) | dcrb_pkg::BIT_DISK);
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 3))
        0: ob = len - 16'd1;
        1: ob = len;
        2: ob = len + 16'($urandom_range(1, 300));
        default: ob = 16'($urandom);
      endcase
      disk_request(1'($urandom), ob);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    read_reg(addr_port(dcrb_pkg::CH_DISK));
    read_reg(addr_port(dcrb_pkg::CH_DISK));
    write_reg(addr_port(dcrb_pkg::CH_DISK), 8'h34);
    write_reg(addr_port(dcrb_pkg::CH_DISK), 8'h12);
    write_reg(count_port(dcrb_pkg::CH_DISK), 8'hff);
    write_reg(count_port(dcrb_pkg::CH_DISK), 8'hff);
    disk_request(1'b1, 16'hffff);            // disk mode bit clear
    write_reg(dcrb_pkg::PORT_STATUS, dcrb_pkg::BIT_DISK);
    disk_request(1'b1, 16'd16383);           // one byte short
    disk_request(1'b1, 16'hffff);            // longest transfer
    read_reg(dcrb_pkg::PORT_STATUS);
    read_reg(dcrb_pkg::PORT_STATUS);
    write_reg(dcrb_pkg::PORT_STATUS, 8'hff); // terminal completes at once
    write_reg(addr_port(dcrb_pkg::CH_TERM), 8'hff);
    write_reg(addr_port(dcrb_pkg::CH_TERM), 8'hff);
    write_reg(dcrb_pkg::PORT_STATUS, dcrb_pkg::BIT_TERM);  // address wraps
    write_reg(dcrb_pkg::PORT_STATUS, dcrb_pkg::BIT_DISK);
    disk_request(1'b0, 16'h0000);            // memory to disk ignores offer
    read_reg(dcrb_pkg::PORT_STATUS + 4'd1);
    write_reg(4'hf, 8'haa);
    send(FUNC_UNUSED, 4'hf, 8'hff, 1'b1, 16'hffff);
    read_reg(count_port(dcrb_pkg::CH_TERM));
    read_reg(count_port(dcrb_pkg::CH_TERM));
    read_reg(dcrb_pkg::PORT_STATUS);
    send(dcrb_pkg::FUNC_DISK, 4'hf, 8'h00, 1'b0, 16'h0000);

    while (sent < 600) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: program_channel();
        4, 5: begin
          read_reg(dcrb_pkg::PORT_STATUS);
          read_reg(4'($urandom_range(0, 7)));
          read_reg(4'($urandom_range(0, 7)));
        end
        6: write_reg(dcrb_pkg::PORT_STATUS, 8'($urandom) | dcrb_pkg::BIT_TERM);
        default: send(2'($urandom), 4'($urandom), 8'($urandom), 1'($urandom),
                      16'($urandom));
      endcase
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run sent %0d register and disk request transfers; %0d channel completions",
             sent, xfer_count);
    $display("were predicted and checked against the result stream.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
